/* sv/olfoc_pkg.sv */
// Shared types, constants and the sine table generator for the open-loop FOC drive.
package olfoc_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] ADDR_INCREMENT = 3'd0;
  localparam logic [2:0] ADDR_AMPLITUDE = 3'd4;

  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [29:0] SQRT3_HALF_Q30 = 30'd929887697;
  localparam logic [15:0] DUTY_MID       = 16'd32768;
  localparam logic [15:0] DUTY_MAX       = 16'd65535;
  localparam logic [15:0] VBUS_MIN_Q8    = 16'd26;
  localparam logic [15:0] VBUS_SUBST_Q8  = 16'd3072;
  localparam int          DIV_BITS       = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL_S,
    ST_MUL_C,
    ST_BETA,
    ST_MUL_K,
    ST_CLARKE,
    ST_MINMAX,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOOK,
    OP_MUL_S,
    OP_MUL_C,
    OP_BETA,
    OP_MUL_K,
    OP_CLARKE,
    OP_MINMAX,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ph;
  } dp_cmd_t;

  // Quarter-wave sine sample in Q16 from an angle in Q30 radians (Taylor series).
  function automatic logic [16:0] sine_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    sum = (sum + 64'd8192) >> 14;
    if (sum > 64'd65536) begin
      sum = 64'd65536;
    end
    return sum[16:0];
  endfunction

endpackage

/* sv/open_loop_foc_svpwm.sv */
// Top level of the open-loop FOC drive with inverse Park transform and SVPWM.
// A tick walks through lookup, multiplies, Clarke, min-max and the divider; start and stop skip to the output.
// A new tick is taken only after the previous one is through: the bit-serial divider runs in turn
// for each of the three phase duties, after the shared multiplier sequence.
// A new input is taken while the previous result still waits in the output register.
// Synchronous active-low reset clears the angle, tick count, encoder echo and both registers.
module open_loop_foc_svpwm #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,    // bus_voltage[15:0], encoder_raw[29:16], zero pad
  input  logic [1:0]   in_tuser,    // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,   // duty_phase_a, duty_phase_b, duty_phase_c,
                                    // electrical_angle, tick_count[31:0],
                                    // encoder_echo[13:0], zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import olfoc_pkg::*;

  localparam logic REG_PHASE_INC = 1'b0;
  localparam logic REG_AMPLITUDE = 1'b1;
  localparam logic [16:0] AMP_ONE = 17'd65536;

  logic [30:0] phase_inc_r;
  logic [16:0] amp_r;
  logic        cfg_write;
  dp_cmd_t     cmd;
  logic        out_free;

  // The configuration port never stalls; a write lands in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      amp_r       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_paddr[2])
        REG_PHASE_INC: phase_inc_r <= cfg_pwdata[30:0];
        REG_AMPLITUDE: amp_r <= (cfg_pwdata[16:0] > AMP_ONE) ? AMP_ONE : cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_PHASE_INC: cfg_prdata = {1'b0, phase_inc_r};
      REG_AMPLITUDE: cfg_prdata = {15'b0, amp_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // The controller steps the datapath through lookup, multiplies, Clarke and the divider.
  olfoc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  olfoc_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_func    (in_tuser),
    .in_bus     (in_tdata[15:0]),
    .in_enc     (in_tdata[29:16]),
    .phase_inc  (phase_inc_r),
    .amplitude  (amp_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_free   (out_free)
  );

  // One item at a time: after a transfer in, the input side is closed in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item still in work");

  // The amplitude register never holds more than unity.
  a_amp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> amp_r <= AMP_ONE)
    else $error("amplitude register above unity");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

/* sv/olfoc_ctrl.sv */
// Sequencing state machine for the FOC datapath.
module olfoc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [1:0]          in_func,
  input  logic                out_free,
  output logic                in_tready,
  output olfoc_pkg::dp_cmd_t  cmd
);
  import olfoc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [3:0]  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.ph    = ph_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = (in_func == FUNC_TICK) ? ST_LOOK : ST_DONE;
        end
      end
      ST_LOOK: begin
        cmd.op = OP_LOOK;
        state_nxt = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.op = OP_MUL_S;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.op = OP_MUL_C;
        state_nxt = ST_BETA;
      end
      ST_BETA: begin
        cmd.op = OP_BETA;
        state_nxt = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.op = OP_MUL_K;
        state_nxt = ST_CLARKE;
      end
      ST_CLARKE: begin
        cmd.op = OP_CLARKE;
        state_nxt = ST_MINMAX;
      end
      ST_MINMAX: begin
        cmd.op = OP_MINMAX;
        ph_nxt = '0;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op = OP_DIV_INIT;
        step_nxt = '0;
        state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd.op = OP_DIV_STEP;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(DIV_BITS - 1)) begin
          state_nxt = ST_DIV_STORE;
        end
      end
      ST_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        if (ph_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          ph_nxt = ph_r + 2'd1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* sv/olfoc_dp.sv */
// Datapath: phase accumulator, sine lookup, shared multiplier, Clarke, SVPWM divider.
module olfoc_dp #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS       = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  olfoc_pkg::dp_cmd_t cmd,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_bus,
  input  logic [13:0]        in_enc,
  input  logic [30:0]        phase_inc,
  input  logic [16:0]        amplitude,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [111:0]       out_tdata,
  output logic               out_free
);
  import olfoc_pkg::*;

  localparam int QS = PHASE_BITS - 2;
  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = QS + IW;
  localparam int SW = (PHASE_BITS > 31) ? PHASE_BITS : 31;
  localparam int MW = 34;
  localparam int PRW = 2 * MW;
  localparam int VW = 36;
  localparam int NW = VW + 2;

  // Quarter-wave table, built at elaboration.
  logic [16:0] sin_tab [0:SINE_TABLE_DEPTH];
  genvar k;
  for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
    assign sin_tab[k] = sine_q16(XK);
  end

  logic [PHASE_BITS-1:0] acc_r;
  logic [31:0]           cnt_r;
  logic [13:0]           enc_r;
  logic [15:0]           vbus_r;
  logic [15:0]           vbd_r;
  logic signed [17:0]    s_r, c_r;
  logic [32:0]           vq_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [MW-1:0]  valpha_r, vbeta_r;
  logic signed [VW-1:0]  v_r [3];
  logic signed [NW-1:0]  n_r [3];
  logic [33:0]           rem_r, dsh_r;
  logic [15:0]           q_r, qfix_r;
  logic                  fix_r;
  logic [15:0]           duty_r [3];
  logic [111:0]          out_data_r;
  logic                  out_valid_r;

  // Phase step and table lookup.
  logic [SW-1:0]         acc_sum;
  logic [PW-1:0]         idx_prod;
  logic [IW-1:0]         idx, ridx;
  logic signed [17:0]    sa, sb, s_nxt, c_nxt;
  logic [1:0]            quad;

  assign acc_sum  = SW'(acc_r) + SW'(phase_inc);
  assign quad     = acc_r[PHASE_BITS-1 -: 2];
  assign idx_prod = PW'(acc_r[QS-1:0]) * PW'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[QS +: IW];
  assign ridx     = IW'(SINE_TABLE_DEPTH) - idx;
  assign sa       = $signed({1'b0, sin_tab[idx]});
  assign sb       = $signed({1'b0, sin_tab[ridx]});

  always_comb begin
    case (quad)
      2'd0:    begin s_nxt = sa;  c_nxt = sb;  end
      2'd1:    begin s_nxt = sb;  c_nxt = -sa; end
      2'd2:    begin s_nxt = -sa; c_nxt = -sb; end
      default: begin s_nxt = -sb; c_nxt = sa;  end
    endcase
  end

  // Shared multiplier.
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;

  always_comb begin
    case (cmd.op)
      OP_LOOK: begin
        mul_a = $signed({17'b0, amplitude});
        mul_b = $signed({18'b0, vbus_r});
      end
      OP_MUL_S: begin
        mul_a = $signed({1'b0, prod_r[32:0]});
        mul_b = MW'(s_r);
      end
      OP_MUL_C: begin
        mul_a = $signed({1'b0, vq_r});
        mul_b = MW'(c_r);
      end
      OP_MUL_K: begin
        mul_a = vbeta_r;
        mul_b = $signed({4'b0, SQRT3_HALF_Q30});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Round a Q16-scaled product to Q0, half away from zero.
  logic                  p_neg;
  logic [PRW-1:0]        p_mag, p_rnd;
  logic signed [MW-1:0]  rnd16;

  assign p_neg = prod_r[PRW-1];
  assign p_mag = p_neg ? PRW'(-prod_r) : PRW'(prod_r);
  assign p_rnd = (p_mag + PRW'(1 << 15)) >> 16;
  assign rnd16 = p_neg ? -$signed(p_rnd[MW-1:0]) : $signed(p_rnd[MW-1:0]);

  function automatic logic signed [VW-1:0] round30(input logic signed [PRW:0] v);
    logic [PRW:0] mag;
    logic [PRW:0] r;
    mag = v[PRW] ? (PRW + 1)'(-v) : (PRW + 1)'(v);
    r   = (mag + (PRW + 1)'(1 << 29)) >> 30;
    return v[PRW] ? -$signed(r[VW-1:0]) : $signed(r[VW-1:0]);
  endfunction

  // Inverse Clarke terms.
  logic signed [PRW:0]   half_a, sum_b, sum_c;
  assign half_a = -((PRW + 1)'(valpha_r) <<< 29);
  assign sum_b  = half_a + (PRW + 1)'(prod_r);
  assign sum_c  = half_a - (PRW + 1)'(prod_r);

  // Min-max zero-sequence terms.
  logic signed [VW-1:0]  mx, mn;
  always_comb begin
    mx = (v_r[0] > v_r[1]) ? v_r[0] : v_r[1];
    mx = (mx > v_r[2]) ? mx : v_r[2];
    mn = (v_r[0] < v_r[1]) ? v_r[0] : v_r[1];
    mn = (mn < v_r[2]) ? mn : v_r[2];
  end

  // Divider setup.
  logic signed [39:0]    num;
  logic [16:0]           d2;
  logic [32:0]           lim;
  assign d2  = {vbd_r, 1'b0};
  assign lim = {d2, 16'b0};
  assign num = $signed({8'b0, vbd_r, 16'b0}) + $signed({24'b0, vbd_r}) + 40'(n_r[cmd.ph]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      enc_r <= '0;
    end else if (cmd.op == OP_ACCEPT) begin
      if (in_func == FUNC_TICK) begin
        acc_r <= acc_sum[PHASE_BITS-1:0];
        cnt_r <= cnt_r + 32'd1;
        enc_r <= in_enc;
      end else if (in_func == FUNC_START) begin
        acc_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        vbus_r <= in_bus;
        if (in_func != FUNC_TICK) begin
          duty_r[0] <= DUTY_MID;
          duty_r[1] <= DUTY_MID;
          duty_r[2] <= DUTY_MID;
        end
      end
      OP_LOOK: begin
        s_r    <= s_nxt;
        c_r    <= c_nxt;
        prod_r <= mul_p;
      end
      OP_MUL_S: begin
        vq_r   <= prod_r[32:0];
        prod_r <= mul_p;
      end
      OP_MUL_C: begin
        valpha_r <= -rnd16;
        prod_r   <= mul_p;
      end
      OP_BETA: vbeta_r <= rnd16;
      OP_MUL_K: prod_r <= mul_p;
      OP_CLARKE: begin
        v_r[0] <= VW'(valpha_r);
        v_r[1] <= round30(sum_b);
        v_r[2] <= round30(sum_c);
      end
      OP_MINMAX: begin
        n_r[0] <= (NW'(v_r[0]) <<< 1) - NW'(mx) - NW'(mn);
        n_r[1] <= (NW'(v_r[1]) <<< 1) - NW'(mx) - NW'(mn);
        n_r[2] <= (NW'(v_r[2]) <<< 1) - NW'(mx) - NW'(mn);
        vbd_r  <= (vbus_r < VBUS_MIN_Q8) ? VBUS_SUBST_Q8 : vbus_r;
      end
      OP_DIV_INIT: begin
        q_r   <= '0;
        rem_r <= num[33:0];
        dsh_r <= {2'b0, d2, 15'b0};
        if (num < 0) begin
          fix_r  <= 1'b1;
          qfix_r <= '0;
        end else if (num >= $signed({7'b0, lim})) begin
          fix_r  <= 1'b1;
          qfix_r <= DUTY_MAX;
        end else begin
          fix_r  <= 1'b0;
          qfix_r <= '0;
        end
      end
      OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          q_r   <= {q_r[14:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_DIV_STORE: duty_r[cmd.ph] <= fix_r ? qfix_r : q_r;
      OP_LOAD: out_data_r <= {2'b0, enc_r, cnt_r, acc_r[PHASE_BITS-1 -: 16],
                              duty_r[2], duty_r[1], duty_r[0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
